[rtl/core/ftlb_pkg.sv]
// Shared types and constants of the FIFO translation buffer.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ftlb_pkg;

   // Buffer geometry.
   localparam int DEPTH   = 16;
   localparam int POS_W   = $clog2(DEPTH);
   localparam int FILL_W  = $clog2(DEPTH + 1);
   localparam int PAGE_W  = 20;
   localparam int FRAME_W = 20;
   localparam int CMD_W   = 2;
   localparam int CNT_W   = 32;

   // Request operation codes.
   localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INVALIDATE = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the incoming request
      logic execute;   // search, update the entries and load the result register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_valid; // the result register holds an undelivered result
   } dp_status_type;

endpackage

[rtl/core/ftlb_channels.sv]
// Valid/ready channel interfaces for requests and results of the translation buffer.
// Depends on ftlb_pkg for field widths.
`timescale 1ns / 1ps

interface ftlb_req_if;
   logic                        valid;
   logic                        ready;
   logic [ftlb_pkg::CMD_W-1:0]   cmd;
   logic [ftlb_pkg::PAGE_W-1:0]  page_number;
   logic [ftlb_pkg::FRAME_W-1:0] frame_in;

   modport source (output valid, output cmd, output page_number, output frame_in,
                   input ready);
   modport sink (input valid, input cmd, input page_number, input frame_in,
                 output ready);
endinterface

interface ftlb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [ftlb_pkg::FRAME_W-1:0] frame_out;
   logic [ftlb_pkg::CNT_W-1:0]   lookup_count;
   logic [ftlb_pkg::CNT_W-1:0]   miss_count;

   modport source (output valid, output hit, output frame_out, output lookup_count,
                   output miss_count, input ready);
   modport sink (input valid, input hit, input frame_out, input lookup_count,
                 input miss_count, output ready);
endinterface

[rtl/core/ftlb_ctrl.sv]
// Controller of the translation buffer: sequences capture and execution of requests.
// Depends on ftlb_pkg for the command and status structs.
`timescale 1ns / 1ps

module ftlb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   input  ftlb_pkg::dp_status_type dp_status,
   output ftlb_pkg::ctrl_cmd_type  dp_cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;
   logic      out_free;

   // The result register can take a new result when empty or draining this cycle.
   assign out_free       = !dp_status.out_valid || rsp_ready;
   assign dp_cmd.capture = req_valid && ready_ff;
   assign dp_cmd.execute = (state_ff == ST_EXEC) && out_free;
   assign req_ready      = ready_ff;

   // Next state: one request at a time, captured in idle and executed in the next state.
   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.capture) begin
               state_in = ST_EXEC;
               ready_in = 1'b0;
            end
         end
         ST_EXEC: begin
            if (dp_cmd.execute) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   // State and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

[rtl/core/ftlb_dp.sv]
// Datapath of the translation buffer: age-ordered entry registers, parallel
// compare, compaction, counters and the result register. Depends on ftlb_pkg.
`timescale 1ns / 1ps

module ftlb_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  ftlb_pkg::ctrl_cmd_type       dp_cmd,
   output ftlb_pkg::dp_status_type      dp_status,
   input  logic [ftlb_pkg::CMD_W-1:0]   req_cmd,
   input  logic [ftlb_pkg::PAGE_W-1:0]  req_page_number,
   input  logic [ftlb_pkg::FRAME_W-1:0] req_frame_in,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [ftlb_pkg::FRAME_W-1:0] rsp_frame_out,
   output logic [ftlb_pkg::CNT_W-1:0]   rsp_lookup_count,
   output logic [ftlb_pkg::CNT_W-1:0]   rsp_miss_count
);

   localparam int D = ftlb_pkg::DEPTH;

   // Captured request.
   logic [ftlb_pkg::CMD_W-1:0]   cmd_ff;
   logic [ftlb_pkg::PAGE_W-1:0]  page_ff;
   logic [ftlb_pkg::FRAME_W-1:0] frame_ff;

   // Entries kept in age order: position 0 is the oldest.
   logic [ftlb_pkg::PAGE_W-1:0]  entry_page_ff  [D];
   logic [ftlb_pkg::FRAME_W-1:0] entry_frame_ff [D];
   logic [ftlb_pkg::FILL_W-1:0]  fill_ff;
   logic [ftlb_pkg::FILL_W-1:0]  fill_in;

   logic [ftlb_pkg::CNT_W-1:0]   lookups_ff;
   logic [ftlb_pkg::CNT_W-1:0]   misses_ff;

   logic                         out_valid_ff;
   logic                         hit_ff;
   logic [ftlb_pkg::FRAME_W-1:0] frame_out_ff;

   logic [D-1:0]                 match;
   logic [D-1:0]                 at_or_after;
   logic                         found;
   logic                         full;
   logic [ftlb_pkg::FRAME_W-1:0] frame_sel;
   logic                         is_lookup;
   logic                         is_insert;
   logic                         is_inval;
   logic                         do_append;
   logic                         do_update;
   logic                         do_remove;

   // Parallel compare against every valid position and one-hot frame select.
   always_comb begin
      frame_sel = '0;
      for (int i = 0; i < D; i++) begin
         match[i] = (ftlb_pkg::FILL_W'(i) < fill_ff) && (entry_page_ff[i] == page_ff);
         if (match[i]) begin
            frame_sel = frame_sel | entry_frame_ff[i];
         end
      end
   end

   // Positions at or after the match; they take the next younger entry on removal.
   always_comb begin
      at_or_after[0] = match[0];
      for (int i = 1; i < D; i++) begin
         at_or_after[i] = at_or_after[i-1] | match[i];
      end
   end

   assign found     = |match;
   assign full      = (fill_ff == ftlb_pkg::FILL_W'(D));
   assign is_lookup = (cmd_ff == ftlb_pkg::CMD_LOOKUP);
   assign is_insert = (cmd_ff == ftlb_pkg::CMD_INSERT);
   assign is_inval  = (cmd_ff == ftlb_pkg::CMD_INVALIDATE);
   assign do_append = dp_cmd.execute && is_insert && !found;
   assign do_update = dp_cmd.execute && is_insert && found;
   assign do_remove = dp_cmd.execute && is_inval && found;

   // Fill count: append grows unless full (oldest evicted), removal shrinks.
   always_comb begin
      fill_in = fill_ff;
      if (do_append && !full) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_remove) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff   <= req_cmd;
         page_ff  <= req_page_number;
         frame_ff <= req_frame_in;
      end
   end

   // Entry storage: update in place, append or shift on eviction, compact on removal.
   always_ff @(posedge clock) begin
      for (int i = 0; i < D; i++) begin
         if (do_update && match[i]) begin
            entry_frame_ff[i] <= frame_ff;
         end else if (do_append && full) begin
            if (i == D - 1) begin
               entry_page_ff[i]  <= page_ff;
               entry_frame_ff[i] <= frame_ff;
            end else begin
               entry_page_ff[i]  <= entry_page_ff[(i+1) % D];
               entry_frame_ff[i] <= entry_frame_ff[(i+1) % D];
            end
         end else if (do_append && (ftlb_pkg::POS_W'(i) == fill_ff[ftlb_pkg::POS_W-1:0])) begin
            entry_page_ff[i]  <= page_ff;
            entry_frame_ff[i] <= frame_ff;
         end else if (do_remove && at_or_after[i] && (i < D - 1)) begin
            entry_page_ff[i]  <= entry_page_ff[(i+1) % D];
            entry_frame_ff[i] <= entry_frame_ff[(i+1) % D];
         end
      end
   end

   // Control state: fill count, saturating counters and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         lookups_ff   <= '0;
         misses_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (dp_cmd.execute && is_lookup) begin
            if (lookups_ff != '1) begin
               lookups_ff <= lookups_ff + 1'b1;
            end
            if (!found && (misses_ff != '1)) begin
               misses_ff <= misses_ff + 1'b1;
            end
         end
         if (dp_cmd.execute) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (dp_cmd.execute) begin
         hit_ff       <= found && (is_lookup || is_insert || is_inval);
         frame_out_ff <= (is_lookup && found) ? frame_sel : '0;
      end
   end

   assign dp_status.out_valid = out_valid_ff;
   assign rsp_valid           = out_valid_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_frame_out       = frame_out_ff;
   assign rsp_lookup_count    = lookups_ff;
   assign rsp_miss_count      = misses_ff;

endmodule

[rtl/core/fifo_tlb.sv]
// Fully associative translation buffer with first-in first-out replacement,
// 16 entries of 20-bit page and frame numbers, held in age order. Every request
// is first captured; then, in the execute state, all entries are compared
// in parallel and the lookup, insert or invalidate (including compaction of the
// younger entries) is done, writing the result register. The next request is
// accepted in the cycle after that, while the result may still wait; execution
// stalls only when the previous result has not been taken. The lookup and miss
// counters saturate at their maximum. Depends on ftlb_pkg, the channel
// interfaces, ftlb_ctrl and ftlb_dp.
`timescale 1ns / 1ps

module fifo_tlb (
   input  logic         clock,
   input  logic         reset,
   ftlb_req_if.sink     req_chan,
   ftlb_rsp_if.source   rsp_chan
);

   ftlb_pkg::ctrl_cmd_type  dp_cmd;
   ftlb_pkg::dp_status_type dp_status;

   // Request sequencing.
   ftlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Entry storage, search and result register.
   ftlb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_cmd          (req_chan.cmd),
      .req_page_number  (req_chan.page_number),
      .req_frame_in     (req_chan.frame_in),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_hit          (rsp_chan.hit),
      .rsp_frame_out    (rsp_chan.frame_out),
      .rsp_lookup_count (rsp_chan.lookup_count),
      .rsp_miss_count   (rsp_chan.miss_count)
   );

   // Misses are a subset of lookups, so never outnumber them.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.miss_count <= rsp_chan.lookup_count))
      else $error("miss count exceeds lookup count");

   // A nonzero frame is only returned with a hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.frame_out != '0)) |-> rsp_chan.hit)
      else $error("frame returned without a hit");

   // One request in flight: an accepted request closes the input for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in flight");

   // The lookup counter never decreases outside reset.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_chan.lookup_count >= $past(rsp_chan.lookup_count)))
      else $error("lookup count decreased");

endmodule

[tb/tb_fifo_tlb.sv]
// Self-checking testbench for the FIFO translation buffer fifo_tlb.
// Depends on ftlb_pkg and the channel interfaces in ftlb_channels.sv. An age-ordered
// model of the entries predicts every result, and the scoreboard checks each field.
`timescale 1ns / 1ps

module tb_fifo_tlb;

   localparam int RANDOM_PER_PHASE = 375;
   localparam int POOL_SIZE        = 24;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int DRAIN_CYCLES     = 10;
   localparam logic [ftlb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Predicts the result of each request and checks the results in order.
   class tlb_scoreboard_type;
      typedef struct packed {
         logic [ftlb_pkg::PAGE_W-1:0]  page;
         logic [ftlb_pkg::FRAME_W-1:0] frame;
      } tlb_entry_type;

      typedef struct packed {
         logic                         hit;
         logic [ftlb_pkg::FRAME_W-1:0] frame;
         logic [ftlb_pkg::CNT_W-1:0]   lookups;
         logic [ftlb_pkg::CNT_W-1:0]   misses;
      } tlb_result_type;

      tlb_entry_type              held_entries[$];    // oldest entry first
      tlb_result_type             pending_results[$];
      logic [ftlb_pkg::CNT_W-1:0] lookups_seen;
      logic [ftlb_pkg::CNT_W-1:0] misses_seen;
      int                         mismatches;
      int                         results_checked;
      int                         evictions;
      int                         invalidates_matched;

      function new();
         lookups_seen        = '0;
         misses_seen         = '0;
         mismatches          = 0;
         results_checked     = 0;
         evictions           = 0;
         invalidates_matched = 0;
      endfunction

      // Updates the entries as the block will and queues the result it must return.
      function void note_request(logic [ftlb_pkg::CMD_W-1:0] cmd,
                                 logic [ftlb_pkg::PAGE_W-1:0] page,
                                 logic [ftlb_pkg::FRAME_W-1:0] frame);
         tlb_result_type outcome;
         tlb_entry_type  fresh;
         int             pos;
         pos = -1;
         foreach (held_entries[i]) begin
            if (pos < 0 && held_entries[i].page == page) pos = i;
         end
         outcome = '0;
         case (cmd)
            ftlb_pkg::CMD_LOOKUP: begin
               if (lookups_seen != '1) lookups_seen++;
               if (pos >= 0) begin
                  outcome.hit   = 1'b1;
                  outcome.frame = held_entries[pos].frame;
               end else if (misses_seen != '1) begin
                  misses_seen++;
               end
            end
            ftlb_pkg::CMD_INSERT: begin
               if (pos >= 0) begin
                  // A page already held keeps its age; only the frame changes.
                  outcome.hit = 1'b1;
                  held_entries[pos].frame = frame;
               end else begin
                  if (held_entries.size() == ftlb_pkg::DEPTH) begin
                     void'(held_entries.pop_front());
                     evictions++;
                  end
                  fresh.page  = page;
                  fresh.frame = frame;
                  held_entries.push_back(fresh);
               end
            end
            ftlb_pkg::CMD_INVALIDATE: begin
               if (pos >= 0) begin
                  outcome.hit = 1'b1;
                  held_entries.delete(pos);
                  invalidates_matched++;
               end
            end
            default: begin
            end
         endcase
         outcome.lookups = lookups_seen;
         outcome.misses  = misses_seen;
         pending_results.push_back(outcome);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("[%0t] MISMATCH: %s", $time, what);
      endtask

      // Compares one delivered result with the oldest expectation.
      task check_result(logic hit, logic [ftlb_pkg::FRAME_W-1:0] frame,
                        logic [ftlb_pkg::CNT_W-1:0] lookups,
                        logic [ftlb_pkg::CNT_W-1:0] misses);
         tlb_result_type want;
         if (pending_results.size() == 0) begin
            report("result delivered with no request outstanding");
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         if (hit !== want.hit)
            report($sformatf("hit got %0b want %0b", hit, want.hit));
         if (frame !== want.frame)
            report($sformatf("frame_out got %h want %h", frame, want.frame));
         if (lookups !== want.lookups)
            report($sformatf("lookup_count got %0d want %0d", lookups, want.lookups));
         if (misses !== want.misses)
            report($sformatf("miss_count got %0d want %0d", misses, want.misses));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   int unsigned        send_idle_pct;
   int unsigned        recv_idle_pct;
   int                 cycle_count = 0;
   int                 requests_sent = 0;
   tlb_scoreboard_type sb = new();

   ftlb_req_if req_if ();
   ftlb_rsp_if rsp_if ();

   fifo_tlb u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, sb.pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: check every accepted result and stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.hit, rsp_if.frame_out, rsp_if.lookup_count,
                            rsp_if.miss_count);
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offers one request, with random idle cycles first, and records it once accepted.
   // Valid stays high when the next request follows without a gap.
   task send_request(logic [ftlb_pkg::CMD_W-1:0] cmd, logic [ftlb_pkg::PAGE_W-1:0] page,
                     logic [ftlb_pkg::FRAME_W-1:0] frame);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.cmd         <= cmd;
      req_if.page_number <= page;
      req_if.frame_in    <= frame;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(cmd, page, frame);
      requests_sent++;
   endtask

   // Random requests over a small page pool, so that hits, evictions and
   // matching invalidates are frequent; a tenth use a fully random page.
   task run_random_phase(int count, int unsigned send_pct, int unsigned recv_pct);
      logic [ftlb_pkg::PAGE_W-1:0] page_pool[POOL_SIZE];
      logic [ftlb_pkg::CMD_W-1:0]  cmd;
      logic [ftlb_pkg::PAGE_W-1:0] page;
      int unsigned                 roll;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = ftlb_pkg::PAGE_W'($urandom);
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 45)      cmd = ftlb_pkg::CMD_LOOKUP;
         else if (roll < 78) cmd = ftlb_pkg::CMD_INSERT;
         else if (roll < 95) cmd = ftlb_pkg::CMD_INVALIDATE;
         else                cmd = CMD_UNUSED;
         if ($urandom_range(9) == 0) page = ftlb_pkg::PAGE_W'($urandom);
         else page = page_pool[$urandom_range(POOL_SIZE - 1)];
         send_request(cmd, page, ftlb_pkg::FRAME_W'($urandom));
      end
   endtask

   initial begin
      req_if.valid       <= 1'b0;
      req_if.cmd         <= ftlb_pkg::CMD_LOOKUP;
      req_if.page_number <= '0;
      req_if.frame_in    <= '0;
      send_idle_pct = 18;
      recv_idle_pct = 73;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty buffer, unused command, extreme pages and frames,
      // update in place, then a fill past capacity and removal from the middle.
      send_request(ftlb_pkg::CMD_LOOKUP, '0, '0);
      send_request(ftlb_pkg::CMD_INVALIDATE, '0, '0);
      send_request(CMD_UNUSED, '1, '1);
      send_request(ftlb_pkg::CMD_INSERT, '0, '0);
      send_request(ftlb_pkg::CMD_INSERT, '1, '1);
      send_request(ftlb_pkg::CMD_LOOKUP, '0, '1);
      send_request(ftlb_pkg::CMD_LOOKUP, '1, '0);
      send_request(ftlb_pkg::CMD_INSERT, '1, 20'h5A5A5);
      send_request(ftlb_pkg::CMD_LOOKUP, '1, '0);
      for (int i = 0; i < 15; i++)
         send_request(ftlb_pkg::CMD_INSERT, ftlb_pkg::PAGE_W'(32'h100 + i),
                      ftlb_pkg::FRAME_W'($urandom));
      send_request(ftlb_pkg::CMD_LOOKUP, '0, '0);
      send_request(ftlb_pkg::CMD_INVALIDATE, ftlb_pkg::PAGE_W'(32'h107), '0);

      run_random_phase(RANDOM_PER_PHASE, 18, 73);
      run_random_phase(RANDOM_PER_PHASE, 73, 18);
      run_random_phase(RANDOM_PER_PHASE, 0, 0);
      req_if.valid <= 1'b0;

      // Let every result arrive, then watch for stray ones.
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests under three stall patterns; %0d results checked.",
               requests_sent, sb.results_checked);
      $display("Lookups %0d (misses %0d), evictions %0d, matched invalidates %0d.",
               sb.lookups_seen, sb.misses_seen, sb.evictions, sb.invalidates_matched);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches found.", sb.mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
